// ===== rtl/pirl_pkg.sv =====
`default_nettype none

package pirl_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // beat field widths
   localparam int KIND_W   = 2;
   localparam int POS_W    = 8;
   localparam int IN_W     = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int READ_W   = 32;

   // width for comparing a position against the entry count
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic signed [POS_W-1:0] position;
      logic [IN_W-1:0]         data;
   } req_type;

   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
   } mem_cmd_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count;
      logic [READ_W-1:0]   read_data;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/pirl_if.sv =====
`default_nettype none

interface pirl_req_if;
   import pirl_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic signed [POS_W-1:0] position;
   logic [IN_W-1:0]         data;

   modport source (output valid, kind, position, data, input ready);
   modport sink   (input valid, kind, position, data, output ready);
endinterface

interface pirl_rsp_if;
   import pirl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;
   logic [READ_W-1:0]   read_data;

   modport source (output valid, status, count, read_data, input ready);
   modport sink   (input valid, status, count, read_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pirl_mem.sv =====
`default_nettype none

module pirl_mem (
   input  logic                           clock,
   input  pirl_pkg::mem_cmd_type          cmd,
   output logic [pirl_pkg::DATA_W-1:0]    rd_data
);
   import pirl_pkg::*;

   logic [DATA_W-1:0] entries_ff [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entries_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      // read data holds while no read is issued
      if (cmd.rd_en) begin
         rd_data_ff <= entries_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pirl_seq.sv =====
`default_nettype none

module pirl_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  pirl_pkg::req_type             req,
   output logic                          req_ready,
   input  logic                          out_free,
   output pirl_pkg::result_type          res,
   output pirl_pkg::mem_cmd_type         mem_cmd,
   input  logic [pirl_pkg::DATA_W-1:0]   rd_data
);
   import pirl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MOVE  = 4'b0010,
      S_FETCH = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type           state_ff,   state_in;
   logic [CNT_W-1:0]    count_ff,   count_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [CNT_W-1:0]    moves_ff,   moves_in;
   logic [IDX_W-1:0]    src_ff,     src_in;
   logic [IDX_W-1:0]    dst_ff,     dst_in;
   logic [IDX_W-1:0]    at_ff,      at_in;
   logic                insert_ff,  insert_in;
   logic [DATA_W-1:0]   word_ff,    word_in;
   logic [STATUS_W-1:0] status_ff,  status_in;
   logic                rd_ok_ff,   rd_ok_in;

   logic [DATA_W-1:0]   word;
   logic                pos_neg;
   logic [CMP_W-1:0]    pos_x;
   logic [CMP_W-1:0]    cnt_x;
   logic [CMP_W-1:0]    at_x;
   logic                pos_bad;

   assign word    = DATA_W'(req.data);
   assign pos_neg = req.position[POS_W-1];
   assign pos_x   = CMP_W'($unsigned(req.position));
   assign cnt_x   = CMP_W'(count_ff);
   assign pos_bad = pos_neg || (pos_x >= cnt_x);
   // insert: out of range means append
   assign at_x    = (pos_neg || (pos_x > cnt_x)) ? cnt_x : pos_x;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      wr_pend_in = wr_pend_ff;
      moves_in   = moves_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      at_in      = at_ff;
      insert_in  = insert_ff;
      word_in    = word_ff;
      status_in  = status_ff;
      rd_ok_in   = rd_ok_ff;
      mem_cmd    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rd_ok_in   = 1'b0;
               wr_pend_in = 1'b0;
               state_in   = S_RESP;
               status_in  = ST_RANGE;
               case (req.kind)
                  KIND_INSERT: begin
                     if (word == '0) begin
                        status_in = ST_NULL;
                     end else if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        insert_in = 1'b1;
                        word_in   = word;
                        at_in     = IDX_W'(at_x);
                        moves_in  = count_ff - CNT_W'(at_x);
                        src_in    = IDX_W'(count_ff - CNT_W'(1));
                        count_in  = count_ff + CNT_W'(1);
                        state_in  = S_MOVE;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!pos_bad) begin
                        status_in = ST_OK;
                        insert_in = 1'b0;
                        moves_in  = count_ff - CNT_W'(pos_x) - CNT_W'(1);
                        src_in    = IDX_W'(pos_x + CMP_W'(1));
                        count_in  = count_ff - CNT_W'(1);
                        state_in  = S_MOVE;
                     end
                  end
                  KIND_READ: begin
                     if (!pos_bad) begin
                        status_in = ST_OK;
                        at_in     = IDX_W'(pos_x);
                        rd_ok_in  = 1'b1;
                        state_in  = S_FETCH;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // write back the word read in the previous cycle
            if (wr_pend_ff) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = dst_ff;
               mem_cmd.wr_data = rd_data;
            end
            if (moves_ff != '0) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = src_ff;
               src_in     = insert_ff ? src_ff - IDX_W'(1) : src_ff + IDX_W'(1);
               dst_in     = insert_ff ? src_ff + IDX_W'(1) : src_ff - IDX_W'(1);
               moves_in   = moves_ff - CNT_W'(1);
               wr_pend_in = 1'b1;
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  if (insert_ff) begin
                     mem_cmd.wr_en   = 1'b1;
                     mem_cmd.wr_addr = at_ff;
                     mem_cmd.wr_data = word_ff;
                  end
                  state_in = S_RESP;
               end
            end
         end
         S_FETCH: begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = at_ff;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         wr_pend_ff <= wr_pend_in;
      end
      moves_ff  <= moves_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      at_ff     <= at_in;
      insert_ff <= insert_in;
      word_ff   <= word_in;
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign res.valid     = (state_ff == S_RESP);
   assign res.status    = status_ff;
   assign res.count     = count_ff;
   assign res.read_data = rd_ok_ff ? READ_W'(rd_data) : '0;

endmodule

`default_nettype wire

// ===== rtl/positional_insert_remove_list.sv =====
// Flow: a rejected item goes from decode straight to the result state, a read passes through
//   a fetch state first, and an insert or remove first shifts its entries in the move state.
// Handshake: one item at a time; the next beat is taken only after the result is registered and
//   the sequencer is back in idle; the shift loop moves one entry per cycle.
// Reset: synchronous, active high; the list is emptied (count zero), list storage is not cleared.
`default_nettype none

module positional_insert_remove_list (
   input  logic        clock,
   input  logic        reset,
   pirl_req_if.sink    req_ch,
   pirl_rsp_if.source  rsp_ch
);
   import pirl_pkg::*;

   req_type              req;
   result_type           res;
   mem_cmd_type          mem_cmd;
   logic [DATA_W-1:0]    rd_data;
   logic                 out_free;

   // result register, parts the sequencer from the rsp side
   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff,  rsp_count_in;
   logic [READ_W-1:0]    rsp_data_ff,   rsp_data_in;

   assign req.kind     = req_ch.kind;
   assign req.position = req_ch.position;
   assign req.data     = req_ch.data;

   // free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer: decodes the beat, then walks the list one entry per cycle with a
   // shared step unit (address +/- 1, move count down), read one slot, write the next.
   pirl_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req       (req),
      .req_ready (req_ch.ready),
      .out_free  (out_free),
      .res       (res),
      .mem_cmd   (mem_cmd),
      .rd_data   (rd_data)
   );

   // List storage, one write and one registered read per cycle
   pirl_mem u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_data_in   = rsp_data_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res.valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res.status;
         // count wraps if the list is ever deeper than the field
         rsp_count_in  = COUNT_W'(res.count);
         rsp_data_in   = res.read_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.count     = rsp_count_ff;
   assign rsp_ch.read_data = rsp_data_ff;

   // entry count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (res.count <= CNT_W'(CAPACITY)))
      else $error("entry count above capacity");

   // a full reject only when the list is really full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_FULL)) |-> (rsp_ch.count == COUNT_W'(CAPACITY)))
      else $error("full status with room left");

   // read data only on a successful beat
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.read_data != '0)) |-> (rsp_ch.status == ST_OK))
      else $error("read data on a failed beat");

   // sequencer busy straight after taking a beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("ready held after accept");

endmodule

`default_nettype wire
